// ===== sv/slt_pkg.sv =====
`default_nettype none

package slt_pkg;

	localparam int CAPACITY = 16;
	localparam int POS_W    = 4;
	localparam int LEN_W    = 5;
	localparam int WORD_W   = 32;
	localparam int CMD_W    = 3;
	localparam int STAT_W   = 3;

	localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd2;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;
	localparam logic [CMD_W-1:0] CMD_FIND   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RESIZE = 3'd6;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_RANGE    = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STAT_W-1:0] ST_BADSIZE  = 3'd4;

	localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

	// broadcast to every cell of the row
	typedef struct packed {
		logic                    go;
		logic [CMD_W-1:0]        cmd;
		logic [LEN_W-1:0]        pos;
		logic [LEN_W-1:0]        len;
		logic [LEN_W-1:0]        req;
		logic signed [WORD_W-1:0] word;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/slt_cell.sv =====
`default_nettype none

module slt_cell import slt_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [LEN_W-1:0]         index,
	input  wire cell_ctrl_t               ctrl,
	input  wire logic signed [WORD_W-1:0] left_val,
	input  wire logic signed [WORD_W-1:0] right_val,
	output logic signed [WORD_W-1:0]      value,
	output logic                          match
);

	logic signed [WORD_W-1:0] val_q;
	logic signed [WORD_W-1:0] val_d;
	logic [LEN_W-1:0]         last_idx;

	assign last_idx = ctrl.len - LEN_W'(1);

	// each command reaches here only when it succeeds
	always_comb begin
		val_d = val_q;
		if (ctrl.go) begin
			unique case (ctrl.cmd)
				CMD_WRITE: begin
					if (index == ctrl.pos) val_d = ctrl.word;
				end
				CMD_APPEND: begin
					if (index == ctrl.len) val_d = ctrl.word;
				end
				CMD_INSERT: begin
					if (index <= ctrl.len) val_d = left_val;
				end
				CMD_DELETE: begin
					if (index == last_idx) val_d = '0;
					else if (index >= ctrl.pos && index < last_idx) val_d = right_val;
				end
				CMD_RESIZE: begin
					if (index >= ctrl.len && index < ctrl.req) val_d = '0;
				end
				default: val_d = val_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else begin
			val_q <= val_d;
		end
	end

	assign value = val_q;
	assign match = (val_q == ctrl.word) && (index < ctrl.len);

endmodule

`default_nettype wire

// ===== sv/shift_list_table_unit.sv =====
// shift_list_table_unit: bounded ordered list of signed 32-bit words
// input channel s_*: one command per transaction; s_tuser carries the command
// code, s_tdata the position, word and requested length
// output channel m_*: exactly one result per command; m_tuser carries the
// status, m_tdata the read word, found position and list length after it
// the list sits in a row of CAPACITY cells; each cell loads, takes its left or
// right neighbor, clears or compares in the same cycle as its peers
// the result is registered: a command accepted at one edge shows its result at m_*
// after that edge
// throughput: one command per cycle while m_tready stays high; the single
// result register is refilled in the cycle it is drained
// when the receiver stalls, the result holds and s_tready drops until the
// result is taken
// reset: all cells and the length clear to zero, no result pending
`default_nettype none

module shift_list_table_unit import slt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // position[3:0], word_in[35:4], new_length[40:36], zero
	input  wire logic [2:0]  s_tuser,  // command[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // word_out[31:0], found_position[35:32],
	                                   // length_now[40:36], zero
	output logic [2:0]       m_tuser   // status[2:0]
);

	logic                     accept;
	logic [CMD_W-1:0]         cmd;
	logic [POS_W-1:0]         pos;
	logic signed [WORD_W-1:0] word;
	logic [LEN_W-1:0]         req;
	logic [LEN_W-1:0]         pos_ext;

	logic [LEN_W-1:0]         len_q;
	logic [LEN_W-1:0]         len_d;
	logic                     m_valid_q;
	logic [STAT_W-1:0]        stat_q;
	logic signed [WORD_W-1:0] rd_q;
	logic [POS_W-1:0]         fpos_q;

	logic [STAT_W-1:0]        stat_d;
	logic signed [WORD_W-1:0] rd_d;
	logic [POS_W-1:0]         fpos_d;
	logic                     in_range;
	logic                     full;
	logic                     bad_size;
	logic                     any_hit;
	logic [POS_W-1:0]         last_hit;

	cell_ctrl_t               ctrl;
	logic signed [WORD_W-1:0] cell_val [CAPACITY];
	logic [CAPACITY-1:0]      hit;

	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign cmd     = s_tuser;
	assign pos     = s_tdata[3:0];
	assign word    = s_tdata[35:4];
	assign req     = s_tdata[40:36];
	assign pos_ext = LEN_W'(pos);

	assign in_range = pos_ext < len_q;
	assign full     = len_q >= CAP_LEN;
	assign bad_size = (req == '0) || (req < len_q) || (req > CAP_LEN);

	// last matching cell wins
	always_comb begin
		any_hit  = 1'b0;
		last_hit = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit[i]) begin
				any_hit  = 1'b1;
				last_hit = POS_W'(i);
			end
		end
	end

	always_comb begin
		stat_d = ST_OK;
		rd_d   = '0;
		fpos_d = '0;
		len_d  = len_q;
		unique case (cmd) inside
			CMD_READ: begin
				if (in_range) rd_d = cell_val[pos];
				else stat_d = ST_RANGE;
			end
			CMD_WRITE: begin
				if (!in_range) stat_d = ST_RANGE;
			end
			CMD_APPEND, CMD_INSERT: begin
				if (full) stat_d = ST_FULL;
				else len_d = len_q + LEN_W'(1);
			end
			CMD_DELETE: begin
				if (in_range) len_d = len_q - LEN_W'(1);
				else stat_d = ST_RANGE;
			end
			CMD_FIND: begin
				if (any_hit) fpos_d = last_hit;
				else stat_d = ST_NOTFOUND;
			end
			CMD_RESIZE: begin
				if (bad_size) stat_d = ST_BADSIZE;
				else len_d = req;
			end
			default: stat_d = ST_OK;
		endcase
	end

	always_comb begin
		ctrl.go   = accept && (stat_d == ST_OK);
		ctrl.cmd  = cmd;
		ctrl.pos  = pos_ext;
		ctrl.len  = len_q;
		ctrl.req  = req;
		ctrl.word = word;
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [WORD_W-1:0] left_v;
		logic signed [WORD_W-1:0] right_v;

		if (g == 0) begin : g_head
			assign left_v = word;
		end else begin : g_mid_l
			assign left_v = cell_val[g-1];
		end
		if (g == CAPACITY - 1) begin : g_tail
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = cell_val[g+1];
		end

		slt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.index     (LEN_W'(g)),
			.ctrl      (ctrl),
			.left_val  (left_v),
			.right_val (right_v),
			.value     (cell_val[g]),
			.match     (hit[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				len_q     <= len_d;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stat_q <= stat_d;
			rd_q   <= rd_d;
			fpos_q <= fpos_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = stat_q;
	assign m_tdata  = {7'd0, len_q, fpos_q, rd_q};

endmodule

`default_nettype wire

// ===== sv/slt_checker.sv =====
`default_nettype none

module slt_checker import slt_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic [2:0]  m_tuser
);

	// a stalled result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a failed command reports no word and no position
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata[35:0] == '0)
		else $error("failed command carries data");

	// length never passes capacity
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[40:36] <= CAP_LEN)
		else $error("length beyond capacity");

	// a new command is taken only when the result slot is empty or drains
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while result stalled");

endmodule

bind shift_list_table_unit slt_checker u_slt_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import slt_pkg::*;

	// code 7 is not decoded by the block and must leave the list alone
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam int MAX_GAP = 19;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [WORD_W-1:0] word;
		logic [POS_W-1:0]  fpos;
		logic [LEN_W-1:0]  len;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;  // position[3:0], word_in[35:4], new_length[40:36], zero
	logic [2:0]  s_tuser;  // command[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;  // word_out[31:0], found_position[35:32], length_now[40:36], zero
	logic [2:0]  m_tuser;  // status[2:0]

	// mirror of the list contents and length
	logic [WORD_W-1:0] list_cells [CAPACITY] = '{default: '0};
	logic [LEN_W-1:0]  list_len = '0;

	outcome_t pending_outcomes[$];
	int       mismatch_count = 0;
	bit       steady = 1'b0;

	shift_list_table_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int pick_gap();
		if (steady)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	function automatic outcome_t apply_list_cmd(input logic [CMD_W-1:0] cmd,
			input logic [POS_W-1:0] pos, input logic [WORD_W-1:0] word,
			input logic [LEN_W-1:0] req);
		outcome_t r;
		int i;
		bit hit;
		r = '0;
		r.status = ST_OK;
		hit = 1'b0;
		case (cmd)
			CMD_READ: begin
				if (pos < list_len)
					r.word = list_cells[pos];
				else
					r.status = ST_RANGE;
			end
			CMD_WRITE: begin
				if (pos < list_len)
					list_cells[pos] = word;
				else
					r.status = ST_RANGE;
			end
			CMD_APPEND: begin
				if (list_len >= CAP_LEN) begin
					r.status = ST_FULL;
				end else begin
					list_cells[list_len] = word;
					list_len = list_len + 1'b1;
				end
			end
			CMD_INSERT: begin
				if (list_len >= CAP_LEN) begin
					r.status = ST_FULL;
				end else begin
					for (i = int'(list_len); i > 0; i--)
						list_cells[i] = list_cells[i - 1];
					list_cells[0] = word;
					list_len = list_len + 1'b1;
				end
			end
			CMD_DELETE: begin
				if (pos < list_len) begin
					for (i = int'(pos); i + 1 < int'(list_len); i++)
						list_cells[i] = list_cells[i + 1];
					// slot past the new tail is cleared
					list_cells[list_len - 1'b1] = '0;
					list_len = list_len - 1'b1;
				end else begin
					r.status = ST_RANGE;
				end
			end
			CMD_FIND: begin
				for (i = 0; i < int'(list_len); i++) begin
					if (list_cells[i] == word) begin
						hit = 1'b1;
						r.fpos = POS_W'(i);
					end
				end
				if (!hit) begin
					r.status = ST_NOTFOUND;
					r.fpos = '0;
				end
			end
			CMD_RESIZE: begin
				if (req == '0 || req < list_len || req > CAP_LEN) begin
					r.status = ST_BADSIZE;
				end else begin
					for (i = int'(list_len); i < int'(req); i++)
						list_cells[i] = '0;
					list_len = req;
				end
			end
			default: begin
			end
		endcase
		r.len = list_len;
		return r;
	endfunction

	task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic [WORD_W-1:0] word, input logic [LEN_W-1:0] req);
		int gap;
		outcome_t predicted;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {7'd0, req, word, pos};
		do @(posedge clk); while (s_tready !== 1'b1);
		predicted = apply_list_cmd(cmd, pos, word, req);
		pending_outcomes.insert(pending_outcomes.size(), predicted);
	endtask

	// drop the last transaction before idling so it is not taken twice
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 20) begin
			case ($urandom_range(0, 4))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'hffff_ffff;
				3: return 32'h0000_0001;
				default: return 32'h0000_0000;
			endcase
		end
		// reuse a stored value so that searches hit
		if (sel < 55)
			return list_cells[$urandom_range(0, CAPACITY - 1)];
		return $urandom;
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		if (list_len != '0 && $urandom_range(0, 99) < 80)
			return POS_W'($urandom_range(0, int'(list_len) - 1));
		return POS_W'($urandom);
	endfunction

	// random opcode, the undecoded one included
	function automatic logic [CMD_W-1:0] CMD_WIDTH_NOISE();
		return CMD_W'($urandom);
	endfunction

	task automatic test_empty_list();
		issue_command(CMD_READ,   4'd0, 32'h0, 5'd0);
		issue_command(CMD_WRITE,  4'd0, 32'hdead_beef, 5'd0);
		issue_command(CMD_DELETE, 4'd0, 32'h0, 5'd0);
		issue_command(CMD_FIND,   4'd0, 32'h0, 5'd0);
		issue_command(CMD_RESIZE, 4'd0, 32'h0, 5'd0);
		issue_command(CMD_RESIZE, 4'd0, 32'h0, 5'd31);
		issue_command(CMD_UNUSED, 4'd15, 32'hffff_ffff, 5'd31);
	endtask

	task automatic test_fill_and_limits();
		issue_command(CMD_APPEND, 4'd0, 32'h7fff_ffff, 5'd0);
		issue_command(CMD_APPEND, 4'd0, 32'h8000_0000, 5'd0);
		issue_command(CMD_INSERT, 4'd0, 32'hffff_ffff, 5'd0);
		issue_command(CMD_APPEND, 4'd0, 32'h7fff_ffff, 5'd0);
		// duplicate value: the last index must be reported
		issue_command(CMD_FIND,   4'd0, 32'h7fff_ffff, 5'd0);
		issue_command(CMD_READ,   4'd0, 32'h0, 5'd0);
		issue_command(CMD_WRITE,  4'd1, 32'h5a5a_5a5a, 5'd0);
		issue_command(CMD_RESIZE, 4'd0, 32'h0, 5'd4);
		issue_command(CMD_RESIZE, 4'd0, 32'h0, 5'd3);
		issue_command(CMD_RESIZE, 4'd0, 32'h0, 5'd16);
		issue_command(CMD_APPEND, 4'd0, 32'h1234_5678, 5'd0);
		issue_command(CMD_INSERT, 4'd0, 32'h1234_5678, 5'd0);
		issue_command(CMD_READ,   4'd15, 32'h0, 5'd0);
		issue_command(CMD_DELETE, 4'd15, 32'h0, 5'd0);
		issue_command(CMD_DELETE, 4'd0, 32'h0, 5'd0);
		issue_command(CMD_READ,   4'd14, 32'h0, 5'd0);
	endtask

	task automatic test_drain_pause();
		issue_command(CMD_INSERT, 4'd0, 32'h0bad_cafe, 5'd0);
		issue_command(CMD_INSERT, 4'd0, 32'h0000_0001, 5'd0);
		wait_drained();
		issue_command(CMD_FIND, 4'd0, 32'h0bad_cafe, 5'd0);
		issue_command(CMD_READ, 4'd0, 32'h0, 5'd0);
	endtask

	task automatic test_random_traffic(input int count);
		int n;
		int sel;
		logic [LEN_W-1:0] req;
		for (n = 0; n < count; n++) begin
			// every third block of 100 runs with no idling on either side
			steady = ((n / 100) % 3) == 1;
			if (n == count / 2)
				wait_drained();
			sel = $urandom_range(0, 99);
			if (sel < 14)
				issue_command(CMD_READ, pick_position(), pick_word(), LEN_W'($urandom));
			else if (sel < 28)
				issue_command(CMD_WRITE, pick_position(), pick_word(), LEN_W'($urandom));
			else if (sel < 40)
				issue_command(CMD_APPEND, POS_W'($urandom), pick_word(), LEN_W'($urandom));
			else if (sel < 52)
				issue_command(CMD_INSERT, POS_W'($urandom), pick_word(), LEN_W'($urandom));
			else if (sel < 73)
				issue_command(CMD_DELETE, pick_position(), pick_word(), LEN_W'($urandom));
			else if (sel < 89)
				issue_command(CMD_FIND, POS_W'($urandom), pick_word(), LEN_W'($urandom));
			else if (sel < 96) begin
				if ($urandom_range(0, 99) < 70)
					req = LEN_W'($urandom_range(int'(list_len), CAPACITY));
				else
					req = LEN_W'($urandom);
				issue_command(CMD_RESIZE, POS_W'($urandom), pick_word(), req);
			end else
				issue_command(CMD_WIDTH_NOISE(), POS_W'($urandom), $urandom, LEN_W'($urandom));
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_list();
		test_fill_and_limits();
		test_drain_pause();
		test_random_traffic(1000);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin : result_checker
		int stall;
		outcome_t seen;
		outcome_t want;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = pick_gap();
			repeat (stall) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			seen.status = m_tuser;
			seen.word   = m_tdata[31:0];
			seen.fpos   = m_tdata[35:32];
			seen.len    = m_tdata[40:36];
			if (pending_outcomes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result transaction: status %0d word %h pos %0d len %0d",
						seen.status, seen.word, seen.fpos, seen.len);
			end else begin
				want = pending_outcomes.pop_front();
				if (seen.status !== want.status || seen.word !== want.word ||
						seen.fpos !== want.fpos || seen.len !== want.len) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: status %0d/%0d word %h/%h pos %0d/%0d len %0d/%0d (exp/got)",
							want.status, seen.status, want.word, seen.word,
							want.fpos, seen.fpos, want.len, seen.len);
				end
			end
		end
	end

	initial begin
		#(5_000_000);
		$display("testbench: FAIL");
		$finish;
	end

endmodule
